>>> design/rse_pkg.sv
// Package for the ROM search engine: item structs, opcode and result kind codes,
// command bytes and fixed widths. No dependencies.
package rse_pkg;

  // Default number of ROM code bits that one search pass walks through.
  localparam int unsigned ROM_BITS_DEF = 64;

  // Width of the bit position and discrepancy counters (holds up to 127; a default pass reaches 65).
  localparam int unsigned POS_W = 7;

  // Family byte discrepancies are tracked only below this position.
  localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;

  // Search command bytes.
  localparam logic [7:0] CMD_NORMAL = 8'hF0;
  localparam logic [7:0] CMD_COND   = 8'hEC;

  // Input opcodes.
  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_TARGET  = 2'd1;
  localparam logic [1:0] OP_START   = 2'd2;
  localparam logic [1:0] OP_BITPAIR = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_ACK   = 3'd0;
  localparam logic [2:0] KIND_CMD   = 3'd1;
  localparam logic [2:0] KIND_DIR   = 3'd2;
  localparam logic [2:0] KIND_FOUND = 3'd3;
  localparam logic [2:0] KIND_NONE  = 3'd4;
  localparam logic [2:0] KIND_IGN   = 3'd5;

  // Depth of the output queue, counted in result pairs.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One input transaction.
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] family_byte;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } in_item_t;

  // All results caused by one input item. A pair carries the direction bit
  // first (kind0/value0) and then the found or not-found result (kind1).
  typedef struct packed {
    logic [2:0]  kind0;
    logic [7:0]  value0;
    logic [2:0]  kind1;
    logic [63:0] rom_code;
    logic        last_device;
    logic [3:0]  family_discrepancy;
    logic        two;
  } res_pair_t;

endpackage

>>> design/rse_in_if.sv
// Input channel of the ROM search engine: valid/ready handshake plus the item fields.
// Standalone; no package dependency.
interface rse_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] family_byte;
  logic       presence;
  logic       id_bit;
  logic       complement_bit;

  modport source (
    output valid, opcode, family_byte, presence, id_bit, complement_bit,
    input  ready
  );

  modport sink (
    input  valid, opcode, family_byte, presence, id_bit, complement_bit,
    output ready
  );
endinterface

>>> design/rse_out_if.sv
// Result channel of the ROM search engine: valid/ready handshake plus the result fields.
// Standalone; no package dependency.
interface rse_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  value;
  logic [63:0] rom_code;
  logic        last_device;
  logic [3:0]  family_discrepancy;
  logic        last_of_run;

  modport source (
    output valid, kind, value, rom_code, last_device, family_discrepancy, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, kind, value, rom_code, last_device, family_discrepancy, last_of_run,
    output ready
  );
endinterface

>>> design/rse_in_stage.sv
// Input register of the ROM search engine: holds one accepted transaction for the core.
// Depends on rse_pkg for the item struct.
module rse_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rse_pkg::in_item_t in_item_i,
  output logic              item_valid_o,
  input  logic              item_take_i,
  output rse_pkg::in_item_t item_o
);

  logic              valid_q;
  logic              valid_d;
  rse_pkg::in_item_t item_q;

  // The register frees up in the same cycle that the core takes its item.
  assign in_ready_o   = !valid_q || item_take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  // Valid flag is control state and is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register loads on every accepted transaction.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

>>> design/rse_core.sv
// Search decision logic and search state of the ROM search engine.
// Depends on rse_pkg for codes, widths and structs.
module rse_core #(
  parameter int unsigned ROM_BITS = rse_pkg::ROM_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                step_i,
  input  rse_pkg::in_item_t   item_i,
  output rse_pkg::res_pair_t  res_o
);

  localparam int unsigned POS_W = rse_pkg::POS_W;
  localparam int unsigned IDX_W = $clog2(ROM_BITS);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(ROM_BITS);
  localparam logic [POS_W-1:0] FIRST_POS = POS_W'(1);

  logic [ROM_BITS-1:0] rom_q, rom_d;
  logic [POS_W-1:0]    ldisc_q, ldisc_d;
  logic                ldev_q, ldev_d;
  logic [3:0]          lfam_q, lfam_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    lzero_q, lzero_d;
  logic                active_q, active_d;
  logic                cond_q;

  logic [IDX_W-1:0]    idx;
  logic                dir;

  // Bit index of the current position; a pass keeps the position within 1..ROM_BITS.
  assign idx = IDX_W'(pos_q - FIRST_POS);

  // One search step for the item in the input register.
  always_comb begin
    rom_d    = rom_q;
    ldisc_d  = ldisc_q;
    ldev_d   = ldev_q;
    lfam_d   = lfam_q;
    pos_d    = pos_q;
    lzero_d  = lzero_q;
    active_d = active_q;
    dir      = 1'b0;
    res_o    = '0;

    case (item_i.opcode)
      rse_pkg::OP_RESTART: begin
        active_d     = 1'b0;
        rom_d        = '0;
        ldisc_d      = '0;
        ldev_d       = 1'b0;
        lfam_d       = '0;
        res_o.kind0  = rse_pkg::KIND_ACK;
      end
      rse_pkg::OP_TARGET: begin
        active_d     = 1'b0;
        rom_d        = ROM_BITS'(item_i.family_byte);
        ldisc_d      = LAST_POS;
        ldev_d       = 1'b0;
        lfam_d       = '0;
        res_o.kind0  = rse_pkg::KIND_ACK;
      end
      rse_pkg::OP_START: begin
        active_d = 1'b0;
        pos_d    = FIRST_POS;
        lzero_d  = '0;
        if (ldev_q || !item_i.presence) begin
          // Nothing left to find, or nobody on the bus.
          ldisc_d     = '0;
          ldev_d      = 1'b0;
          lfam_d      = '0;
          res_o.kind0 = rse_pkg::KIND_NONE;
        end else begin
          active_d     = 1'b1;
          res_o.kind0  = rse_pkg::KIND_CMD;
          res_o.value0 = cond_q ? rse_pkg::CMD_COND : rse_pkg::CMD_NORMAL;
        end
      end
      default: begin
        if (!active_q) begin
          res_o.kind0 = rse_pkg::KIND_IGN;
        end else if (item_i.id_bit && item_i.complement_bit) begin
          // No device answered this bit.
          active_d    = 1'b0;
          ldisc_d     = '0;
          ldev_d      = 1'b0;
          lfam_d      = '0;
          res_o.kind0 = rse_pkg::KIND_NONE;
        end else begin
          if (item_i.id_bit != item_i.complement_bit) begin
            dir = item_i.id_bit;
          end else begin
            // Discrepancy: follow the previous path below the last
            // discrepancy, take the one branch at it, the zero branch above.
            if (pos_q < ldisc_q) begin
              dir = rom_q[idx];
            end else begin
              dir = (pos_q == ldisc_q);
            end
            if (!dir) begin
              lzero_d = pos_q;
              if (pos_q < rse_pkg::FAMILY_LIMIT) begin
                lfam_d = pos_q[3:0];
              end
            end
          end
          rom_d[idx]   = dir;
          pos_d        = pos_q + FIRST_POS;
          res_o.kind0  = rse_pkg::KIND_DIR;
          res_o.value0 = {7'b0, dir};

          // The last bit closes the pass with a second result.
          if (pos_q == LAST_POS) begin
            active_d  = 1'b0;
            ldisc_d   = lzero_d;
            res_o.two = 1'b1;
            if (lzero_d == '0) begin
              ldev_d = 1'b1;
            end
            if (rom_d[7:0] == 8'd0) begin
              ldisc_d     = '0;
              ldev_d      = 1'b0;
              lfam_d      = '0;
              res_o.kind1 = rse_pkg::KIND_NONE;
            end else begin
              res_o.kind1    = rse_pkg::KIND_FOUND;
              res_o.rom_code = 64'(rom_d);
            end
          end
        end
      end
    endcase

    res_o.last_device        = ldev_d;
    res_o.family_discrepancy = lfam_d;
  end

  // Search state, updated once per item taken from the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q    <= '0;
      ldisc_q  <= '0;
      ldev_q   <= 1'b0;
      lfam_q   <= '0;
      pos_q    <= FIRST_POS;
      lzero_q  <= '0;
      active_q <= 1'b0;
    end else if (step_i) begin
      rom_q    <= rom_d;
      ldisc_q  <= ldisc_d;
      ldev_q   <= ldev_d;
      lfam_q   <= lfam_d;
      pos_q    <= pos_d;
      lzero_q  <= lzero_d;
      active_q <= active_d;
    end
  end

  // Search mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_q <= 1'b0;
    end else if (cfg_we_i) begin
      cond_q <= cfg_wdata_i;
    end
  end

endmodule

>>> design/rse_out_queue.sv
// Result queue of the ROM search engine: stores result pairs and hands them out one
// transaction at a time. Depends on rse_pkg for the pair struct and kind codes.
module rse_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rse_pkg::res_pair_t pair_i,
  output logic               can_push_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         kind_o,
  output logic [7:0]         value_o,
  output logic [63:0]        rom_code_o,
  output logic               last_device_o,
  output logic [3:0]         family_discrepancy_o,
  output logic               last_of_run_o
);

  localparam int unsigned DEPTH = rse_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rse_pkg::res_pair_t mem_q [DEPTH];
  rse_pkg::res_pair_t head;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               half_q, half_d;
  logic               out_fire;
  logic               pop;

  assign head        = mem_q[rd_ptr_q];
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;

  // An entry leaves once its last transaction has gone out.
  assign pop        = out_fire && (!head.two || half_q);
  assign can_push_o = (count_q != CNT_W'(DEPTH)) || pop;

  // Present the first or the second half of the head entry.
  always_comb begin
    kind_o               = head.kind0;
    value_o              = head.value0;
    rom_code_o           = '0;
    last_of_run_o        = 1'b1;
    last_device_o        = head.last_device;
    family_discrepancy_o = head.family_discrepancy;
    if (head.two) begin
      if (half_q) begin
        kind_o     = head.kind1;
        value_o    = '0;
        rom_code_o = head.rom_code;
      end else begin
        last_of_run_o = 1'b0;
      end
    end
  end

  // Pointer, count and half-select updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    half_d   = half_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      half_d   = 1'b0;
    end else if (out_fire) begin
      half_d = 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      half_q   <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      half_q   <= half_d;
    end
  end

  // Entry storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= pair_i;
    end
  end

endmodule

>>> design/rom_search_engine.sv
// ROM search engine for a single-wire bus: decides each step of the ROM search.
// ROM search engine top level; depends on rse_pkg, rse_in_if, rse_out_if,
// rse_in_stage, rse_core and rse_out_queue.
//
// Usage:
//   in_i carries one command per transaction: restart search, target a family,
//   start a pass (with the presence result), or a sampled id/complement bit pair.
//   out_o returns the results: ack, the search command byte, the direction bit
//   to write, device found with its ROM code, not found, or ignored.
//   cfg_we_i/cfg_wdata_i set the search mode (normal or conditional search);
//   write it only while no transaction is in flight.
// Path: an accepted input transaction is held in the input register, then the step
//   logic writes its results into the result queue, which offers them on out_o.
// Throughput: one input transaction per cycle while the result queue has room. The
//   last bit pair of a pass gives two result transactions, which the single output
//   port of the result queue hands out on out_o one after the other.
// Reset: rst_ni clears the search state (ROM register, discrepancies, flags,
//   bit position 1), the mode register, the input register and the result queue.
// Stall: when out_o.ready is low the result queue fills (two entries plus the
//   input register) and then in_i.ready drops; nothing is lost or repeated.
module rom_search_engine #(
  parameter int unsigned ROM_BITS = rse_pkg::ROM_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rse_in_if.sink        in_i,
  rse_out_if.source     out_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);

  rse_pkg::in_item_t  in_item;
  rse_pkg::in_item_t  item;
  rse_pkg::res_pair_t pair;
  logic               item_valid;
  logic               can_push;
  logic               step;

  // Pack the input transaction fields.
  assign in_item.opcode         = in_i.opcode;
  assign in_item.family_byte    = in_i.family_byte;
  assign in_item.presence       = in_i.presence;
  assign in_item.id_bit         = in_i.id_bit;
  assign in_item.complement_bit = in_i.complement_bit;

  // The core steps whenever an item is held and the queue has room.
  assign step = item_valid && can_push;

  rse_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_take_i  (step),
    .item_o       (item)
  );

  rse_core #(
    .ROM_BITS (ROM_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item),
    .res_o       (pair)
  );

  rse_out_queue u_out_queue (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push_i               (step),
    .pair_i               (pair),
    .can_push_o           (can_push),
    .out_valid_o          (out_o.valid),
    .out_ready_i          (out_o.ready),
    .kind_o               (out_o.kind),
    .value_o              (out_o.value),
    .rom_code_o           (out_o.rom_code),
    .last_device_o        (out_o.last_device),
    .family_discrepancy_o (out_o.family_discrepancy),
    .last_of_run_o        (out_o.last_of_run)
  );

endmodule

>>> design/rse_checker.sv
// Port-level checks for the ROM search engine result channel, bound to the top level.
// Depends on rse_pkg for the result kind codes.
module rse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [2:0]  kind_i,
  input logic [7:0]  value_i,
  input logic [63:0] rom_code_i,
  input logic        last_of_run_i
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result withdrawn while stalled");

  // A found device always closes the run of results of its input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (kind_i == rse_pkg::KIND_FOUND) |-> last_of_run_i)
    else $error("found result not last of its run");

  // The second result of a pair follows right after the first is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_i && !last_of_run_i |=> valid_i &&
      ((kind_i == rse_pkg::KIND_FOUND) || (kind_i == rse_pkg::KIND_NONE)))
    else $error("pass end result missing after last direction bit");

  // Only a direction bit may be the non-final result of a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !last_of_run_i |-> (kind_i == rse_pkg::KIND_DIR))
    else $error("unexpected non-final result kind");

  // Outside command and direction results, value is zero and the ROM code is zero unless found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (kind_i != rse_pkg::KIND_CMD) && (kind_i != rse_pkg::KIND_DIR) |->
      (value_i == 8'd0) && ((kind_i == rse_pkg::KIND_FOUND) || (rom_code_i == 64'd0)))
    else $error("stray value or ROM code on result");

endmodule

bind rom_search_engine rse_checker u_rse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (out_o.valid),
  .ready_i       (out_o.ready),
  .kind_i        (out_o.kind),
  .value_i       (out_o.value),
  .rom_code_i    (out_o.rom_code),
  .last_of_run_i (out_o.last_of_run)
);
